// ----- rtl/core/huffman_tree_bit_decoder_unit_macros.svh -----
// Assertion macros for the checker file.
`ifndef HUFFMAN_TREE_BIT_DECODER_UNIT_MACROS_SVH
`define HUFFMAN_TREE_BIT_DECODER_UNIT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define HTBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check an implication on every clock edge outside reset.
`define HTBD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/htbd_pkg.sv -----
`timescale 1ns / 1ps
package htbd_pkg;

  localparam int unsigned NodesDefault     = 512;
  localparam int unsigned MaxCodeLenDefault = 16;
  localparam int unsigned SymbolCountDefault = 256;

  localparam int unsigned LenW = 6;
  localparam logic [7:0]  SymNewline = 8'd10;

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_SEG    = 2'd1,
    MODE_DECODE = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_SEG,
    CMD_DEC
  } cmd_kind_e;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FULL = 2'd1,
    STATUS_MISS = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LWALK,
    S_LCHK,
    S_DCUR,
    S_DNXT,
    S_EMIT
  } back_state_e;

  typedef struct packed {
    cmd_kind_e       kind;
    logic [7:0]      sym;
    logic [15:0]     code;
    logic [LenW-1:0] len;
    logic [15:0]     limit;
    logic            sbit;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  symbol;
    logic        symbol_valid;
    logic        segment_done;
    logic [31:0] bit_position;
    status_e     status;
  } res_t;

endpackage

// ----- rtl/core/htbd_fifo.sv -----
`timescale 1ns / 1ps
module htbd_fifo #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] wdata_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] rdata_o,
  output logic         empty_o
);

  logic [W-1:0] mem_q [2];
  logic         wptr_q, rptr_q;
  logic [1:0]   cnt_q;
  logic         do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  // Store the incoming beat
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) wptr_q <= ~wptr_q;
      if (do_pop)  rptr_q <= ~rptr_q;
      if (do_push && !do_pop) cnt_q <= cnt_q + 2'd1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule

// ----- rtl/core/htbd_front.sv -----
`timescale 1ns / 1ps
module htbd_front #(
  parameter int unsigned MAX_CODE_LEN = htbd_pkg::MaxCodeLenDefault,
  parameter int unsigned SYMBOL_COUNT = htbd_pkg::SymbolCountDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           full_o,
  input  logic [1:0]     mode_i,
  input  logic [7:0]     symbol_in_i,
  input  logic [15:0]    code_bits_i,
  input  logic [4:0]     code_length_i,
  input  logic [15:0]    line_limit_i,
  input  logic           stream_bit_i,
  input  logic           cmd_pop_i,
  output htbd_pkg::cmd_t cmd_o,
  output logic           cmd_empty_o
);

  htbd_pkg::cmd_t cmd;
  logic           keep;
  logic [htbd_pkg::LenW-1:0] len_ext;
  logic [$bits(htbd_pkg::cmd_t)-1:0] q_rdata;

  assign len_ext = {1'b0, code_length_i};

  // Classify the beat; drop unused modes and out-of-range load symbols, clamp the length
  always_comb begin
    cmd.sym   = symbol_in_i;
    cmd.code  = code_bits_i;
    cmd.len   = (len_ext > htbd_pkg::LenW'(MAX_CODE_LEN)) ?
                htbd_pkg::LenW'(MAX_CODE_LEN) : len_ext;
    cmd.limit = line_limit_i;
    cmd.sbit  = stream_bit_i;
    cmd.kind  = htbd_pkg::CMD_DEC;
    keep      = 1'b0;
    unique case (htbd_pkg::mode_e'(mode_i))
      htbd_pkg::MODE_LOAD: begin
        cmd.kind = htbd_pkg::CMD_LOAD;
        keep     = ({1'b0, symbol_in_i} < 9'(SYMBOL_COUNT));
      end
      htbd_pkg::MODE_SEG: begin
        cmd.kind = htbd_pkg::CMD_SEG;
        keep     = 1'b1;
      end
      htbd_pkg::MODE_DECODE: begin
        cmd.kind = htbd_pkg::CMD_DEC;
        keep     = 1'b1;
      end
      htbd_pkg::MODE_NONE: begin
        keep     = 1'b0;
      end
      default: keep = 1'b0;
    endcase
  end

  htbd_fifo #(
    .W($bits(htbd_pkg::cmd_t))
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i && keep),
    .wdata_i (cmd),
    .full_o  (full_o),
    .pop_i   (cmd_pop_i),
    .rdata_o (q_rdata),
    .empty_o (cmd_empty_o)
  );

  assign cmd_o = htbd_pkg::cmd_t'(q_rdata);

endmodule

// ----- rtl/core/htbd_back.sv -----
`timescale 1ns / 1ps
module htbd_back #(
  parameter int unsigned NODES        = htbd_pkg::NodesDefault,
  parameter int unsigned MAX_CODE_LEN = htbd_pkg::MaxCodeLenDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  htbd_pkg::cmd_t cmd_i,
  input  logic           cmd_empty_i,
  output logic           cmd_pop_o,
  output htbd_pkg::res_t res_o,
  output logic           res_push_o,
  input  logic           res_full_i,
  output logic           clearing_o
);

  localparam int unsigned IW = $clog2(NODES);
  localparam int unsigned NW = IW + 1;
  localparam int unsigned KW = $clog2(MAX_CODE_LEN + 1);

  htbd_pkg::back_state_e state_q, state_d;

  // Node store
  logic [IW-1:0] left_mem  [NODES];
  logic [IW-1:0] right_mem [NODES];
  logic [7:0]    sym_mem   [NODES];

  logic [IW-1:0] rd_addr, wr_addr, wr_child;
  logic [7:0]    wr_sym;
  logic          we_l, we_r, we_s;
  logic [IW-1:0] rl_q, rr_q;
  logic [7:0]    rs_q;

  logic [IW-1:0] clr_q, clr_d;
  logic [IW-1:0] node_q, node_d;
  logic [KW-1:0] k_q, k_d;
  logic [15:0]   code_q, code_d;
  logic [7:0]    sym_q, sym_d;
  logic [NW-1:0] free_q, free_d;
  logic [IW-1:0] cursor_q, cursor_d;
  logic [15:0]   line_q, line_d;
  logic [15:0]   limit_q, limit_d;
  logic [31:0]   bitcnt_q, bitcnt_d;
  logic          bit_q, bit_d;
  logic [31:0]   pos_q, pos_d;
  logic [IW-1:0] nxt_q, nxt_d;
  htbd_pkg::res_t res_q, res_d;

  logic [31:0]   code_ext;
  logic [KW-1:0] kpos;
  logic          code_bit;
  logic [IW-1:0] slot, dnext;
  logic          leaf, clr_last, store_full;
  logic [15:0]   line_inc;
  logic          seg_hit;

  assign code_ext   = {16'b0, code_q};
  assign kpos       = k_q - KW'(1);
  assign code_bit   = code_ext[5'(kpos)];
  assign slot       = code_bit ? rr_q : rl_q;
  assign dnext      = bit_q ? rr_q : rl_q;
  assign leaf       = (rl_q == '0) && (rr_q == '0);
  assign clr_last   = (clr_q == IW'(NODES - 1));
  assign store_full = (free_q == NW'(NODES));
  assign line_inc   = ((rs_q == htbd_pkg::SymNewline) && (line_q != 16'hFFFF)) ?
                      line_q + 16'd1 : line_q;
  assign seg_hit    = (line_inc >= limit_q);

  // Write and read the node store
  always_ff @(posedge clk_i) begin
    if (we_l) left_mem[wr_addr]  <= wr_child;
    if (we_r) right_mem[wr_addr] <= wr_child;
    if (we_s) sym_mem[wr_addr]   <= wr_sym;
    rl_q <= left_mem[rd_addr];
    rr_q <= right_mem[rd_addr];
    rs_q <= sym_mem[rd_addr];
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      htbd_pkg::S_CLEAR: if (clr_last) state_d = htbd_pkg::S_IDLE;
      htbd_pkg::S_IDLE: begin
        if (!cmd_empty_i) begin
          unique case (cmd_i.kind)
            htbd_pkg::CMD_LOAD: state_d = htbd_pkg::S_LWALK;
            htbd_pkg::CMD_DEC:  state_d = htbd_pkg::S_DCUR;
            default:            state_d = htbd_pkg::S_IDLE;
          endcase
        end
      end
      htbd_pkg::S_LWALK: state_d = (k_q == '0) ? htbd_pkg::S_IDLE : htbd_pkg::S_LCHK;
      htbd_pkg::S_LCHK: begin
        state_d = ((slot == '0) && store_full) ? htbd_pkg::S_EMIT : htbd_pkg::S_LWALK;
      end
      htbd_pkg::S_DCUR: state_d = (dnext == '0) ? htbd_pkg::S_EMIT : htbd_pkg::S_DNXT;
      htbd_pkg::S_DNXT: state_d = htbd_pkg::S_EMIT;
      htbd_pkg::S_EMIT: if (!res_full_i) state_d = htbd_pkg::S_IDLE;
      default: state_d = htbd_pkg::S_IDLE;
    endcase
  end

  // Datapath and store controls
  always_comb begin
    clr_d    = clr_q;
    node_d   = node_q;
    k_d      = k_q;
    code_d   = code_q;
    sym_d    = sym_q;
    free_d   = free_q;
    cursor_d = cursor_q;
    line_d   = line_q;
    limit_d  = limit_q;
    bitcnt_d = bitcnt_q;
    bit_d    = bit_q;
    pos_d    = pos_q;
    nxt_d    = nxt_q;
    res_d    = res_q;
    rd_addr  = cursor_q;
    wr_addr  = node_q;
    wr_child = '0;
    wr_sym   = '0;
    we_l     = 1'b0;
    we_r     = 1'b0;
    we_s     = 1'b0;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    unique case (state_q)
      htbd_pkg::S_CLEAR: begin
        // Sweep the store to zero
        wr_addr = clr_q;
        we_l    = 1'b1;
        we_r    = 1'b1;
        we_s    = 1'b1;
        clr_d   = clr_q + IW'(1);
      end
      htbd_pkg::S_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.kind)
            htbd_pkg::CMD_LOAD: begin
              node_d = '0;
              k_d    = KW'(cmd_i.len);
              code_d = cmd_i.code;
              sym_d  = cmd_i.sym;
            end
            htbd_pkg::CMD_SEG: begin
              limit_d = cmd_i.limit;
              line_d  = '0;
            end
            default: begin
              bit_d    = cmd_i.sbit;
              pos_d    = bitcnt_q;
              bitcnt_d = (bitcnt_q != 32'hFFFF_FFFF) ? bitcnt_q + 32'd1 : bitcnt_q;
              rd_addr  = cursor_q;
            end
          endcase
        end
      end
      htbd_pkg::S_LWALK: begin
        // Label the reached node, or fetch its children
        rd_addr = node_q;
        if (k_q == '0) begin
          wr_addr = node_q;
          wr_sym  = sym_q;
          we_s    = 1'b1;
        end
      end
      htbd_pkg::S_LCHK: begin
        k_d = kpos;
        if (slot == '0) begin
          if (store_full) begin
            res_d = '{symbol: '0, symbol_valid: 1'b0, segment_done: 1'b0,
                      bit_position: '0, status: htbd_pkg::STATUS_FULL};
          end else begin
            wr_addr  = node_q;
            wr_child = free_q[IW-1:0];
            we_l     = !code_bit;
            we_r     = code_bit;
            node_d   = free_q[IW-1:0];
            free_d   = free_q + NW'(1);
          end
        end else begin
          node_d = slot;
        end
      end
      htbd_pkg::S_DCUR: begin
        rd_addr = dnext;
        nxt_d   = dnext;
        if (dnext == '0) begin
          cursor_d = '0;
          res_d = '{symbol: '0, symbol_valid: 1'b0, segment_done: 1'b0,
                    bit_position: pos_q, status: htbd_pkg::STATUS_MISS};
        end
      end
      htbd_pkg::S_DNXT: begin
        if (leaf) begin
          cursor_d = '0;
          line_d   = seg_hit ? 16'd0 : line_inc;
          res_d = '{symbol: rs_q, symbol_valid: 1'b1, segment_done: seg_hit,
                    bit_position: pos_q, status: htbd_pkg::STATUS_OK};
        end else begin
          cursor_d = nxt_q;
          res_d = '{symbol: '0, symbol_valid: 1'b0, segment_done: 1'b0,
                    bit_position: pos_q, status: htbd_pkg::STATUS_OK};
        end
      end
      htbd_pkg::S_EMIT: begin
        res_push_o = !res_full_i;
      end
      default: ;
    endcase
  end

  assign res_o      = res_q;
  assign clearing_o = (state_q == htbd_pkg::S_CLEAR);

  // Hold payload
  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    code_q <= code_d;
    sym_q  <= sym_d;
    bit_q  <= bit_d;
    pos_q  <= pos_d;
    nxt_q  <= nxt_d;
    res_q  <= res_d;
    node_q <= node_d;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= htbd_pkg::S_CLEAR;
      clr_q    <= '0;
      free_q   <= NW'(1);
      cursor_q <= '0;
      line_q   <= '0;
      limit_q  <= '0;
      bitcnt_q <= '0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      free_q   <= free_d;
      cursor_q <= cursor_d;
      line_q   <= line_d;
      limit_q  <= limit_d;
      bitcnt_q <= bitcnt_d;
    end
  end

endmodule

// ----- rtl/core/huffman_tree_bit_decoder_unit.sv -----
`timescale 1ns / 1ps
// Decode bit: the back end steps through S_IDLE, S_DCUR, S_DNXT and S_EMIT (S_DNXT is
// skipped on a missing branch); the node store has a registered read port, and a full
// result queue holds S_EMIT. Load entry: one store read and one check per code bit.
// Segment start is handled in S_IDLE alone. Reset (async, active low) clears all
// control state and starts a sweep that zeroes every entry of the node store.
module huffman_tree_bit_decoder_unit #(
  parameter int unsigned NODES        = htbd_pkg::NodesDefault,
  parameter int unsigned MAX_CODE_LEN = htbd_pkg::MaxCodeLenDefault,
  parameter int unsigned SYMBOL_COUNT = htbd_pkg::SymbolCountDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  symbol_in_i,
  input  logic [15:0] code_bits_i,
  input  logic [4:0]  code_length_i,
  input  logic [15:0] line_limit_i,
  input  logic        stream_bit_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  symbol_o,
  output logic        symbol_valid_o,
  output logic        segment_done_o,
  output logic [31:0] bit_position_o,
  output logic [1:0]  status_o
);

  htbd_pkg::cmd_t cmd;
  htbd_pkg::res_t res, res_out;
  logic cmd_empty, cmd_pop, res_push, res_full, clearing, front_full;
  logic [$bits(htbd_pkg::res_t)-1:0] res_rdata;

  // Block the input during the store sweep
  assign full = front_full || clearing;

  htbd_front #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .SYMBOL_COUNT (SYMBOL_COUNT)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push && !clearing),
    .full_o        (front_full),
    .mode_i        (mode_i),
    .symbol_in_i   (symbol_in_i),
    .code_bits_i   (code_bits_i),
    .code_length_i (code_length_i),
    .line_limit_i  (line_limit_i),
    .stream_bit_i  (stream_bit_i),
    .cmd_pop_i     (cmd_pop),
    .cmd_o         (cmd),
    .cmd_empty_o   (cmd_empty)
  );

  htbd_back #(
    .NODES        (NODES),
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_o       (res),
    .res_push_o  (res_push),
    .res_full_i  (res_full),
    .clearing_o  (clearing)
  );

  htbd_fifo #(
    .W($bits(htbd_pkg::res_t))
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_rdata),
    .empty_o (empty)
  );

  // Unpack the oldest result
  assign res_out        = htbd_pkg::res_t'(res_rdata);
  assign symbol_o       = res_out.symbol;
  assign symbol_valid_o = res_out.symbol_valid;
  assign segment_done_o = res_out.segment_done;
  assign bit_position_o = res_out.bit_position;
  assign status_o       = res_out.status;

endmodule

// ----- rtl/core/htbd_checker.sv -----
`timescale 1ns / 1ps
`include "huffman_tree_bit_decoder_unit_macros.svh"
module htbd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic [7:0]  symbol_o,
  input logic        symbol_valid_o,
  input logic        segment_done_o,
  input logic [31:0] bit_position_o,
  input logic [1:0]  status_o
);

  // An error result never carries a symbol
  `HTBD_ASSERT_IMP(a_err_no_sym, !empty && (status_o != htbd_pkg::STATUS_OK), !symbol_valid_o, "error result carries a symbol")
  // Segment end comes only with a decoded symbol
  `HTBD_ASSERT_IMP(a_done_sym, !empty && segment_done_o, symbol_valid_o, "segment_done without symbol")
  // No decoded symbol means a zero symbol field
  `HTBD_ASSERT_IMP(a_sym_zero, !empty && !symbol_valid_o, symbol_o == 8'd0, "stray symbol bits")
  // Store-full results come from loads and carry no position
  `HTBD_ASSERT(a_full_pos, empty || (status_o != htbd_pkg::STATUS_FULL) || (bit_position_o == 32'd0), "store-full result has a position")

endmodule

bind huffman_tree_bit_decoder_unit htbd_checker u_htbd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .empty          (empty),
  .symbol_o       (symbol_o),
  .symbol_valid_o (symbol_valid_o),
  .segment_done_o (segment_done_o),
  .bit_position_o (bit_position_o),
  .status_o       (status_o)
);
